// ===== src/grid_local_maximum_finder_assert.svh =====
// Assertion macros used by the checker of the grid local maximum finder.
`ifndef GRID_LOCAL_MAXIMUM_FINDER_ASSERT_SVH
`define GRID_LOCAL_MAXIMUM_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/glmf_pkg.sv =====
// Shared types, constants and helpers of the grid local maximum finder.
`default_nettype none

package glmf_pkg;

    localparam int MAX_COLS    = 32;
    localparam int PIX_W       = 16;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 5;
    localparam int WIDTH_W     = 6;
    localparam int SLOT_W      = 2;
    localparam int NUM_SLOTS   = 3;
    localparam int STORE_DEPTH = NUM_SLOTS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // A line store entry is the pixel plus a flag saying it is not below its upper neighbour.
    localparam int ENTRY_W     = PIX_W + 1;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int NUM_DEC     = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_MIN    = 6'd2;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX    = WIDTH_W'(MAX_COLS);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 6'd32;
    localparam logic [ROW_W-1:0]   HEIGHT_MIN   = 10'd2;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 10'd32;
    localparam logic [ROW_W-1:0]   ROW_ALL_ONES = '1;
    localparam logic [SLOT_W-1:0]  SLOT_FIRST   = 2'd0;
    localparam logic [SLOT_W-1:0]  SLOT_LAST    = 2'd2;

    // Positions of the three decisions one item can trigger, in output order.
    localparam int DEC_ABOVE = 0;   // the cell one row up, same column
    localparam int DEC_LEFT  = 1;   // on the last row, the cell to the left
    localparam int DEC_HERE  = 2;   // on the last row and column, the cell itself

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_value;
        logic                    frame_start;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0] peak_row;
        logic [COL_W-1:0] peak_col;
        logic             last_of_run;
    } t_result;

    // One classified item as handed from the front end to the back end.
    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        t_slot                   cur_slot;
        t_slot                   prev_slot;
        logic                    row_zero;
        logic                    has_right;
        logic                    last_row;
        logic                    last_col;
        logic                    col_ge1;
        logic                    col_ge2;
    } t_cmd;

    function automatic t_addr store_addr(input t_slot slot, input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
    endfunction

endpackage

`default_nettype wire

// ===== src/glmf_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module glmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

`default_nettype wire

// ===== src/glmf_front.sv =====
// Front end: configuration registers, raster counters and item classification.
`default_nettype none

module glmf_front import glmf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_item                  i_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_cmd
);

    logic [WIDTH_W-1:0] r_frame_width;
    logic [ROW_W-1:0]   r_frame_height;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    t_slot              r_slot;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    t_slot              n_slot;

    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               restart;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    t_slot              slot;
    logic [WIDTH_W-1:0] col_inc;
    logic [ROW_W:0]     row_inc;
    logic               accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;
    assign o_q_push    = accept;

    always_comb begin
        if (r_frame_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_frame_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_frame_width;
        end
        h_eff = (r_frame_height < HEIGHT_MIN) ? HEIGHT_MIN : r_frame_height;
    end

    // A new grid starts on the marker, and also when the counters have run past a geometry
    // that was made smaller.
    assign restart = i_item.frame_start || ({1'b0, r_col} >= w_eff) || (r_row >= h_eff);
    assign row     = restart ? '0 : r_row;
    assign col     = restart ? '0 : r_col;
    assign slot    = restart ? SLOT_FIRST : r_slot;
    assign col_inc = {1'b0, col} + WIDTH_W'(1);
    assign row_inc = {1'b0, row} + (ROW_W + 1)'(1);

    always_comb begin
        o_cmd.pixel     = i_item.pixel_value;
        o_cmd.row       = row;
        o_cmd.col       = col;
        o_cmd.cur_slot  = slot;
        o_cmd.prev_slot = (slot == SLOT_FIRST) ? SLOT_LAST : slot - SLOT_W'(1);
        o_cmd.row_zero  = (row == '0);
        o_cmd.has_right = (col_inc < w_eff);
        o_cmd.last_row  = (row_inc == {1'b0, h_eff});
        o_cmd.last_col  = (col_inc == w_eff);
        o_cmd.col_ge1   = (col != '0);
        o_cmd.col_ge2   = (col > COL_W'(1));
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_slot = r_slot;
        if (accept) begin
            if (col_inc >= w_eff) begin
                n_col = '0;
                if (row_inc >= {1'b0, h_eff}) begin
                    n_row  = '0;
                    n_slot = SLOT_FIRST;
                end else begin
                    n_row  = row_inc[ROW_W-1:0];
                    n_slot = (slot == SLOT_LAST) ? SLOT_FIRST : slot + SLOT_W'(1);
                end
            end else begin
                n_row  = row;
                n_col  = col_inc[COL_W-1:0];
                n_slot = slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_row          <= '0;
            r_col          <= '0;
            r_slot         <= SLOT_FIRST;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[WIDTH_W-1:0];
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[ROW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/glmf_cmd_q.sv =====
// Short queue of classified items between the front end and the back end.
`default_nettype none

module glmf_cmd_q import glmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CMDQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/glmf_back.sv =====
// Back end: line store access, peak decisions and the result register.
`default_nettype none

module glmf_back import glmf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_cmd                    r_cmd;
    logic                    r_busy;
    logic [NUM_DEC-1:0]      r_sent;
    logic                    r_byp_a;
    logic                    r_byp_b;
    logic [ENTRY_W-1:0]      r_byp_data;
    logic signed [PIX_W-1:0] r_p_left;
    logic signed [PIX_W-1:0] r_x1;
    logic signed [PIX_W-1:0] r_x2;
    t_result                 r_out;
    logic                    r_out_valid;
    logic                    n_out_valid;

    logic [ENTRY_W-1:0]      ram_a;
    logic [ENTRY_W-1:0]      ram_b;
    logic [ENTRY_W-1:0]      p_right;
    logic [ENTRY_W-1:0]      p_mid;
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] pm;
    logic signed [PIX_W-1:0] pr;
    logic                    pm_up_ok;
    logic [NUM_DEC-1:0]      emit;
    logic [NUM_DEC-1:0]      pending;
    logic [NUM_DEC-1:0]      sel;
    logic [NUM_DEC-1:0]      after;
    logic                    out_room;
    logic                    push_out;
    logic                    retire;
    logic                    load;
    t_addr                   rd_addr_a;
    t_addr                   rd_addr_b;
    t_addr                   wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    t_result                 res;

    // The row above lives in the previous slot: the right neighbour and the centre are read
    // as the item enters the decide stage, the left one is the centre of the item before.
    assign rd_addr_a = store_addr(i_q_cmd.prev_slot, i_q_cmd.col + COL_W'(1));
    assign rd_addr_b = store_addr(i_q_cmd.prev_slot, i_q_cmd.col);
    assign wr_addr   = store_addr(r_cmd.cur_slot, r_cmd.col);

    glmf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_wr_en     (retire),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (load),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    // A read that hits the entry being written in the same cycle takes the new data.
    assign p_right  = r_byp_a ? r_byp_data : ram_a;
    assign p_mid    = r_byp_b ? r_byp_data : ram_b;
    assign x        = r_cmd.pixel;
    assign pm       = $signed(p_mid[PIX_W-1:0]);
    assign pm_up_ok = p_mid[PIX_W];
    assign pr       = $signed(p_right[PIX_W-1:0]);
    assign wr_data  = {(r_cmd.row_zero || (x >= pm)), x};

    always_comb begin
        emit[DEC_ABOVE] = !r_cmd.row_zero && pm_up_ok && (pm >= x)
                          && (!r_cmd.col_ge1 || (pm >= r_p_left))
                          && (!r_cmd.has_right || (pm >= pr));
        emit[DEC_LEFT]  = r_cmd.last_row && r_cmd.col_ge1 && (r_x1 >= r_p_left)
                          && (!r_cmd.col_ge2 || (r_x1 >= r_x2)) && (r_x1 >= x);
        emit[DEC_HERE]  = r_cmd.last_row && r_cmd.last_col && (x >= pm) && (x >= r_x1);
    end

    assign pending  = r_busy ? (emit & ~r_sent) : '0;
    assign sel      = pending & (~pending + NUM_DEC'(1));
    assign after    = pending & ~sel;
    assign out_room = !r_out_valid || i_pop;
    assign push_out = (|pending) && out_room;
    assign retire   = r_busy && (!(|pending) || (push_out && (after == '0)));
    assign load     = !i_q_empty && (!r_busy || retire);
    assign o_q_pop  = load;

    always_comb begin
        res.peak_row    = r_cmd.row;
        res.peak_col    = r_cmd.col;
        res.last_of_run = (after == '0);
        if (sel[DEC_ABOVE]) begin
            res.peak_row = r_cmd.row - ROW_W'(1);
        end else if (sel[DEC_LEFT]) begin
            res.peak_col = r_cmd.col - COL_W'(1);
        end
    end

    always_comb begin
        if (push_out) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (load) begin
                r_busy <= 1'b1;
            end else if (retire) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd      <= i_q_cmd;
            r_sent     <= '0;
            r_byp_a    <= retire && (wr_addr == rd_addr_a);
            r_byp_b    <= retire && (wr_addr == rd_addr_b);
            r_byp_data <= wr_data;
        end else if (push_out) begin
            r_sent <= r_sent | sel;
        end
        if (retire) begin
            r_p_left <= pm;
            r_x2     <= r_x1;
            r_x1     <= x;
        end
        if (push_out) begin
            r_out <= res;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== src/grid_local_maximum_finder.sv =====
// Top level of the four-neighbour grid local maximum finder.
//
// Grid values arrive in raster order through a queue-style port (push/full) and the row and
// column of every peak leave through a second one (empty/pop); a peak is a value not below
// any of its up, down, left and right neighbours that lie inside the grid. Each cell is
// decided as soon as its last neighbour has come in, so an item usually yields the verdict on
// the cell directly above it, and on the last row also the cell to its left and, at the last
// column, itself; last_of_run marks the final result of one input item. The front end counts
// rows and columns and classifies each item, a two-entry queue decouples it from the back end,
// and the back end reads the row above from a three-row line store (a 96-entry RAM with one
// write and two registered read ports), decides, writes the item back and hands results to a
// one-deep output register. An item with at most one result retires from the decide stage as it
// hands over that result, so one transfer per clock is sustained in both directions while pop is
// held high; on the last row an item can produce up to two results and the last one up to three,
// and those items stay in the decide stage until all their results are handed over, because the
// output port carries one result per transfer. An item passes from the command queue through the
// decide register into the output register. No clearing pass is needed after reset. Configuration
// writes are always taken (cfg_ready stays high) and should only be made while no accepted item
// still has results to deliver; register 0 is the grid width (clamped to 2..32), register 1 the
// grid height (at least 2). frame_start on an item begins a new grid at row 0, column 0.
`default_nettype none

module grid_local_maximum_finder import glmf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  t_item                  i_item,
    output logic                   empty,
    input  logic                   pop,
    output t_result                o_result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Hand-over between the front end and the command queue.
    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;

    // Hand-over between the command queue and the back end.
    logic q_pop;
    logic q_empty;
    t_cmd q_out_cmd;

    // The input side is full exactly when the command queue cannot take another item.
    assign full = q_full;

    glmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_cmd       (q_in_cmd)
    );

    glmf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    // The back end keeps the window of neighbours and emits one result per transfer.
    glmf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ===== src/glmf_checker.sv =====
// Port-level checker of the grid local maximum finder and its bind to the top level.
`default_nettype none

`include "grid_local_maximum_finder_assert.svh"

module glmf_checker import glmf_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   push,
    input logic                   full,
    input t_item                  i_item,
    input logic                   empty,
    input logic                   pop,
    input t_result                o_result,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // The register port never holds a write back.
    `GLMF_ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready, "configuration write refused")

    // A waiting result stays put until it is taken.
    `GLMF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(o_result), "waiting result changed before transfer")

    // Nothing is pending straight after reset.
    `GLMF_ASSERT_SAME(a_empty_after_reset, $rose(i_rst_n), empty, "result present straight after reset")

    // The largest grid has 1023 rows, so a peak row never reaches the all-ones code.
    `GLMF_ASSERT_SAME(a_row_in_range, !empty, o_result.peak_row != ROW_ALL_ONES, "peak row out of range")

endmodule

bind grid_local_maximum_finder glmf_checker u_checker (.*);

`default_nettype wire

// ===== tb/grid_local_maximum_finder_tb.sv =====
// Self-checking testbench for the four-neighbour grid local maximum finder.
module grid_local_maximum_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import glmf_pkg::*;

    // Every input of the block has a known value from time zero onwards.
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    t_item                  i_item      = '0;
    logic                   empty;
    logic                   pop         = 1'b0;
    t_result                o_result;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    grid_local_maximum_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The block is held in reset once, at the start of the run.
    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Peak predictor. It keeps its own three-row line store, row and column
    // counters and copy of the two geometry registers, and turns each
    // accepted pixel into the peaks that pixel lets the block decide.
    // ------------------------------------------------------------------
    logic signed [PIX_W-1:0] line_mem [NUM_SLOTS][MAX_COLS];
    int                      row_cnt    = 0;
    int                      col_cnt    = 0;
    int                      slot_cnt   = 0;
    logic [WIDTH_W-1:0]      geo_width  = WIDTH_RESET;
    logic [ROW_W-1:0]        geo_height = HEIGHT_RESET;

    // Peaks predicted but not yet seen on the output, oldest first.
    t_result pending_peaks [$];
    // Pixels waiting to be offered to the block.
    t_item   pixel_queue [$];

    int items_queued = 0;
    int items_taken  = 0;
    int peaks_seen   = 0;
    int fail_count   = 0;

    // Set at every rising edge to say whether each channel made a transfer there.
    bit in_fired  = 1'b0;
    bit out_fired = 1'b0;
    bit cfg_fired = 1'b0;

    // A cell is a peak when it is not below any neighbour that exists; the
    // up and down neighbours are only looked at when the caller says they exist.
    function automatic bit cell_is_peak(int s, int col, int w, bit has_up, int su,
                                        bit has_dn, int sd);
        logic signed [PIX_W-1:0] v;
        v = line_mem[s][col];
        if (has_up && v < line_mem[su][col]) return 1'b0;
        if (has_dn && v < line_mem[sd][col]) return 1'b0;
        if (col >= 1 && v < line_mem[s][col-1]) return 1'b0;
        if (col + 1 < w && v < line_mem[s][col+1]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_result peak_at(int r, int c);
        t_result pk;
        pk.peak_row    = ROW_W'(r);
        pk.peak_col    = COL_W'(c);
        pk.last_of_run = 1'b0;
        return pk;
    endfunction

    function automatic void predict_peaks(t_item it);
        int      w, h, r, c, cur, prev, prev2;
        t_result found [$];
        // Out-of-range geometry is clamped: width to 2..32, height to at least 2.
        w = int'(geo_width);
        if (w < 2) w = 2;
        if (w > MAX_COLS) w = MAX_COLS;
        h = int'(geo_height);
        if (h < 2) h = 2;
        // A new grid starts on frame_start, and also when shrunk registers
        // leave the counters outside the grid.
        if (it.frame_start || col_cnt >= w || row_cnt >= h) begin
            row_cnt  = 0;
            col_cnt  = 0;
            slot_cnt = 0;
        end
        r     = row_cnt;
        c     = col_cnt;
        cur   = slot_cnt;
        prev  = (cur + 2) % NUM_SLOTS;
        prev2 = (cur + 1) % NUM_SLOTS;
        line_mem[cur][c] = it.pixel_value;
        // The cell above now has its last neighbour; on the last row the cell
        // to the left is complete too, and at the last column this one as well.
        if (r >= 1 && cell_is_peak(prev, c, w, r >= 2, prev2, 1'b1, cur))
            found.push_back(peak_at(r - 1, c));
        if (r == h - 1) begin
            if (c >= 1 && cell_is_peak(cur, c - 1, w, 1'b1, prev, 1'b0, cur))
                found.push_back(peak_at(r, c - 1));
            if (c == w - 1 && cell_is_peak(cur, c, w, 1'b1, prev, 1'b0, cur))
                found.push_back(peak_at(r, c));
        end
        if (found.size() > 0) found[found.size() - 1].last_of_run = 1'b1;
        foreach (found[i]) pending_peaks.push_back(found[i]);
        // Step to the next cell; after the last cell of the grid everything
        // returns to zero, so the next pixel begins a fresh grid.
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt  = 0;
            row_cnt  = r + 1;
            slot_cnt = (cur + 1) % NUM_SLOTS;
            if (row_cnt >= h) begin
                row_cnt  = 0;
                slot_cnt = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Idling. Each side draws a wait per transfer. The mode changes now and
    // then, so that there are stretches with no idling at all, stretches of
    // long random waits and stretches of occasional waits.
    // ------------------------------------------------------------------
    function automatic int draw_wait(inout int mode);
        if ($urandom_range(0, 19) == 0) mode = $urandom_range(0, 2);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    int in_gap   = 0;
    int in_mode  = 0;
    int out_gap  = 0;
    int out_mode = 1;
    int hold_cnt = 0;
    bit held_once = 1'b0;

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge: configuration
    // transfers update the predictor's registers, accepted pixels are fed to
    // the predictor, and each result transfer is checked against the oldest
    // predicted peak.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_pk;
        in_fired  = i_rst_n && push && !full;
        out_fired = i_rst_n && pop && !empty;
        cfg_fired = i_rst_n && cfg_valid && cfg_ready;
        if (cfg_fired) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: geo_width  = i_cfg_data[WIDTH_W-1:0];
                default:         geo_height = i_cfg_data[ROW_W-1:0];
            endcase
        end
        if (in_fired) begin
            predict_peaks(i_item);
            items_taken++;
        end
        if (out_fired) begin
            peaks_seen++;
            if (pending_peaks.size() == 0) begin
                $error("peak_row/peak_col: no peak expected, got row %0d col %0d",
                       o_result.peak_row, o_result.peak_col);
                fail_count++;
            end else begin
                exp_pk = pending_peaks.pop_front();
                if (o_result.peak_row !== exp_pk.peak_row) begin
                    $error("peak_row: expected %0d, actual %0d",
                           exp_pk.peak_row, o_result.peak_row);
                    fail_count++;
                end
                if (o_result.peak_col !== exp_pk.peak_col) begin
                    $error("peak_col: expected %0d, actual %0d",
                           exp_pk.peak_col, o_result.peak_col);
                    fail_count++;
                end
                if (o_result.last_of_run !== exp_pk.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           exp_pk.last_of_run, o_result.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver. At each falling edge it either keeps the current pixel
    // on offer, or, once that pixel's transfer has happened, waits out its
    // drawn gap and then offers the next pixel from the queue. The next
    // values are worked out first so that push gets one assignment per edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic  nxt_push;
        t_item nxt_item;
        nxt_push = push;
        nxt_item = i_item;
        if (i_rst_n) begin
            if (in_fired) nxt_push = 1'b0;
            if (!nxt_push) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pixel_queue.size() > 0) begin
                    nxt_item = pixel_queue.pop_front();
                    nxt_push = 1'b1;
                    in_gap   = draw_wait(in_mode);
                end
            end
        end
        push   <= nxt_push;
        i_item <= nxt_item;
    end

    // ------------------------------------------------------------------
    // Result receiver. After each result transfer it draws a wait before it
    // pops again. Once, when plenty of pixels are still queued, it holds off
    // for a long stretch while the driver carries on, so that the block
    // fills up and has to raise full.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fired) out_gap = draw_wait(out_mode);
            if (!held_once && peaks_seen >= 20 && pixel_queue.size() > 20) begin
                held_once = 1'b1;
                hold_cnt  = 120;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_fired);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(logic signed [PIX_W-1:0] v, bit fs);
        t_item it;
        it.pixel_value = v;
        it.frame_start = fs;
        pixel_queue.push_back(it);
        items_queued++;
    endtask

    // Waits until every queued pixel has made its transfer and every predicted
    // peak has arrived, and then waits on, since the last pixel may have caused
    // no peak and still be inside the pipeline.
    task automatic drain();
        do @(negedge i_clk);
        while (items_taken != items_queued || pending_peaks.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Small values give plenty of ties, which exercise the not-below rule;
    // full-range values make every bit of the pixel toggle.
    function automatic logic signed [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:          return 16'sh8000;
            1:          return 16'sh7fff;
            2, 3, 4, 5: return PIX_W'($urandom_range(0, 6) - 3);
            default:    return PIX_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: a short directed part, then random phases, each phase
    // writing the geometry while the block is idle and then queueing whole
    // grids with random content and the odd stray frame_start.
    // ------------------------------------------------------------------
    initial begin
        int w, h, we, he, n, rand_items;
        rand_items = 0;
        wait (i_rst_n);
        @(negedge i_clk);

        // Smallest grid, with both extremes of the pixel value.
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(WIDTH_MIN));
        write_reg(CFG_FRAME_HEIGHT, HEIGHT_MIN);
        queue_pixel(16'sh8000, 1'b1);
        queue_pixel(16'sh7fff, 1'b0);
        queue_pixel(16'sh7fff, 1'b0);
        queue_pixel(16'sh8000, 1'b0);
        drain();

        // Width and height below the minimum are clamped to 2. Equal values make
        // every cell a peak, so the final pixel yields three results.
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
        for (int k = 0; k < 4; k++) queue_pixel(16'sd5, k == 0);
        drain();

        // A flat three by two grid: ties everywhere.
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
        for (int k = 0; k < 6; k++) queue_pixel(16'sd0, k == 0);
        drain();

        // Stop part-way through a four by four grid, then shrink the width
        // below the column counter: the counters restart without frame_start.
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(4));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(4));
        for (int k = 0; k < 6; k++) queue_pixel(random_pixel(), k == 0);
        drain();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
        for (int k = 0; k < 4; k++) queue_pixel(random_pixel(), 1'b0);

        while (rand_items < 500) begin
            // Mostly small grids; now and then the extremes of both registers.
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 5))
                    0:       w = 0;
                    1:       w = 1;
                    2:       w = 2;
                    3:       w = 32;
                    4:       w = 33;
                    default: w = 63;
                endcase
                case ($urandom_range(0, 3))
                    0:       h = 0;
                    1:       h = 1;
                    2:       h = 2;
                    default: h = 1023;
                endcase
            end else begin
                w = $urandom_range(2, 8);
                h = $urandom_range(2, 6);
            end
            drain();
            // The upper data bits of a width write are ignored by the block.
            write_reg(CFG_FRAME_WIDTH, {4'($urandom), 6'(w)});
            write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
            we = (w < 2) ? 2 : ((w > MAX_COLS) ? MAX_COLS : w);
            he = (h < 2) ? 2 : h;
            n  = we * he * $urandom_range(1, 3);
            if (n > 120) n = $urandom_range(40, 120);
            // The first pixel of a phase always starts a grid, so nothing from
            // an earlier geometry is ever looked at.
            for (int k = 0; k < n; k++)
                queue_pixel(random_pixel(), k == 0 || $urandom_range(0, 39) == 0);
            rand_items += n;
        end

        drain();
        if (fail_count == 0) begin
            $display("grid_local_maximum_finder: match");
        end else begin
            $display("grid_local_maximum_finder: mismatch");
        end
        $finish;
    end

    // Safety net against a hung handshake: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("grid_local_maximum_finder: mismatch");
        $finish;
    end

endmodule
